/* src/signed_int_to_decimal_digits_assert.svh */
// assertion macros for the signed integer to decimal digits block
// expects i_clk and i_rst_n in the scope of every use
`ifndef SIGNED_INT_TO_DECIMAL_DIGITS_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_DIGITS_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define SITDD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("sitdd assertion failed");
// condition that must never be seen outside reset
`define SITDD_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("sitdd forbidden condition seen");
`else
`define SITDD_ASSERT(label, prop)
`define SITDD_ASSERT_NEVER(label, expr)
`endif

`endif

/* src/sitdd_pkg.sv */
// shared constants and types for the signed integer to decimal digits block
// no dependencies
package sitdd_pkg;

    localparam int VALUE_WIDTH = 32;
    // decimal digits of 2**(VALUE_WIDTH-1): floor(n*log10(2))+1, log10(2) ~ 1233/4096
    localparam int NUM_DIGITS  = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
    localparam int BCD_WIDTH   = NUM_DIGITS * 4;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_MINUS,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift_out;
        logic emit_minus;
        logic emit_digit;
        logic last;
    } t_ctrl_cmd;

    typedef struct packed {
        logic negative;
        logic top_zero;
    } t_ctrl_sts;

endpackage

/* src/sitdd_datapath.sv */
// datapath: magnitude shift register, bcd double-dabble register, result registers
// depends on sitdd_pkg
module sitdd_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [sitdd_pkg::VALUE_WIDTH-1:0] i_value,
    input  sitdd_pkg::t_ctrl_cmd              i_cmd,
    output sitdd_pkg::t_ctrl_sts              o_sts,
    output logic                              o_valid,
    output logic                              o_is_minus,
    output logic [3:0]                        o_digit,
    output logic                              o_last
);

    logic [sitdd_pkg::VALUE_WIDTH-1:0] r_mag;
    logic [sitdd_pkg::BCD_WIDTH-1:0]   r_bcd;
    logic [sitdd_pkg::BCD_WIDTH-1:0]   w_adj;
    logic [3:0]                        w_top;
    logic                              r_neg;
    logic                              r_valid;
    logic                              r_is_minus;
    logic [3:0]                        r_digit;
    logic                              r_last;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < sitdd_pkg::NUM_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    assign w_top = r_bcd[sitdd_pkg::BCD_WIDTH-1 -: 4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[sitdd_pkg::VALUE_WIDTH-1];
            r_mag <= i_value[sitdd_pkg::VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;
            r_bcd <= '0;
        end else if (i_cmd.dabble) begin
            r_bcd <= {w_adj[sitdd_pkg::BCD_WIDTH-2:0], r_mag[sitdd_pkg::VALUE_WIDTH-1]};
            r_mag <= {r_mag[sitdd_pkg::VALUE_WIDTH-2:0], 1'b0};
        end else if (i_cmd.shift_out) begin
            r_bcd <= r_bcd << 4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_minus | i_cmd.emit_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_minus <= i_cmd.emit_minus;
        r_digit    <= i_cmd.emit_minus ? 4'd0 : w_top;
        r_last     <= i_cmd.emit_digit & i_cmd.last;
    end

    assign o_sts.negative = r_neg;
    assign o_sts.top_zero = (w_top == 4'd0);
    assign o_valid        = r_valid;
    assign o_is_minus     = r_is_minus;
    assign o_digit        = r_digit;
    assign o_last         = r_last;

endmodule

/* src/sitdd_ctrl.sv */
// controller: sequences load, double-dabble steps, minus token and digit readout
// depends on sitdd_pkg and the assertion macro header
`include "signed_int_to_decimal_digits_assert.svh"

module sitdd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  sitdd_pkg::t_ctrl_sts i_sts,
    output sitdd_pkg::t_ctrl_cmd o_cmd,
    output logic                 o_busy
);

    sitdd_pkg::t_state               r_state;
    sitdd_pkg::t_state               n_state;
    logic [sitdd_pkg::BIT_CNT_W-1:0] r_bit_cnt;
    logic [sitdd_pkg::BIT_CNT_W-1:0] n_bit_cnt;
    logic [sitdd_pkg::DIG_CNT_W-1:0] r_dig_cnt;
    logic [sitdd_pkg::DIG_CNT_W-1:0] n_dig_cnt;
    logic                            r_seen;
    logic                            n_seen;
    logic                            w_conv_done;
    logic                            w_skip;
    logic                            w_final;

    assign w_conv_done = (r_bit_cnt == sitdd_pkg::BIT_CNT_W'(sitdd_pkg::VALUE_WIDTH - 1));
    // leading zero that is not the ones digit
    assign w_skip  = i_sts.top_zero && !r_seen && (r_dig_cnt > sitdd_pkg::DIG_CNT_W'(1));
    assign w_final = (r_dig_cnt == sitdd_pkg::DIG_CNT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sitdd_pkg::S_IDLE: begin
                if (i_start) n_state = sitdd_pkg::S_CONV;
            end
            sitdd_pkg::S_CONV: begin
                if (w_conv_done) begin
                    n_state = i_sts.negative ? sitdd_pkg::S_MINUS : sitdd_pkg::S_OUT;
                end
            end
            sitdd_pkg::S_MINUS: begin
                n_state = sitdd_pkg::S_OUT;
            end
            sitdd_pkg::S_OUT: begin
                if (!w_skip && w_final) n_state = sitdd_pkg::S_IDLE;
            end
            default: begin
                n_state = sitdd_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            sitdd_pkg::S_IDLE: begin
                o_cmd.load = i_start;
            end
            sitdd_pkg::S_CONV: begin
                o_cmd.dabble = 1'b1;
            end
            sitdd_pkg::S_MINUS: begin
                o_cmd.emit_minus = 1'b1;
            end
            sitdd_pkg::S_OUT: begin
                o_cmd.shift_out  = 1'b1;
                o_cmd.emit_digit = !w_skip;
                o_cmd.last       = !w_skip && w_final;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // counters
    always_comb begin
        n_bit_cnt = r_bit_cnt;
        n_dig_cnt = r_dig_cnt;
        n_seen    = r_seen;
        if (o_cmd.load) begin
            n_bit_cnt = '0;
            n_seen    = 1'b0;
        end
        if (o_cmd.dabble) begin
            n_bit_cnt = r_bit_cnt + 1'b1;
            n_dig_cnt = sitdd_pkg::DIG_CNT_W'(sitdd_pkg::NUM_DIGITS);
        end
        if (o_cmd.shift_out) begin
            n_dig_cnt = r_dig_cnt - 1'b1;
        end
        if (o_cmd.emit_digit) begin
            n_seen = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sitdd_pkg::S_IDLE;
            r_bit_cnt <= '0;
            r_dig_cnt <= '0;
            r_seen    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
            r_dig_cnt <= n_dig_cnt;
            r_seen    <= n_seen;
        end
    end

    assign o_busy = (r_state != sitdd_pkg::S_IDLE);

    `SITDD_ASSERT(a_conv_ends, (r_state == sitdd_pkg::S_CONV && w_conv_done) |=> (r_state != sitdd_pkg::S_CONV))
    `SITDD_ASSERT(a_minus_then_out, (r_state == sitdd_pkg::S_MINUS) |=> (r_state == sitdd_pkg::S_OUT))
    `SITDD_ASSERT_NEVER(a_out_underflow, r_state == sitdd_pkg::S_OUT && r_dig_cnt == '0)

endmodule

/* src/signed_int_to_decimal_digits.sv */
// signed 32-bit integer to decimal digit run, a new value taken only while idle:
// VALUE_WIDTH serial double-dabble steps, a minus token for a negative value, then
// each bcd digit position scanned from the top (leading zeros dropped silently)
// first digit follows the dabble steps and any minus token; each dropped zero holds it back
// results are one-cycle strobes that cannot be stalled; the last one leaves with busy low
// synchronous active-low reset: controller idle, no strobe, payload registers not cleared
`include "signed_int_to_decimal_digits_assert.svh"

module signed_int_to_decimal_digits (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic [sitdd_pkg::VALUE_WIDTH-1:0] i_value,
    output logic                              busy,
    output logic                              o_valid,
    output logic                              o_is_minus,
    output logic [3:0]                        o_digit,
    output logic                              o_last
);

    // command and status between controller and datapath
    sitdd_pkg::t_ctrl_cmd w_cmd;
    sitdd_pkg::t_ctrl_sts w_sts;

    // controller: load on start while idle, dabble, minus, digit readout
    sitdd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // datapath: magnitude, bcd register and registered result item
    sitdd_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (i_value),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_valid    (o_valid),
        .o_is_minus (o_is_minus),
        .o_digit    (o_digit),
        .o_last     (o_last)
    );

    // the minus token never closes a run and carries digit zero
    `SITDD_ASSERT_NEVER(a_minus_not_last, o_valid && o_is_minus && o_last)
    `SITDD_ASSERT(a_minus_digit_zero, (o_valid && o_is_minus) |-> (o_digit == 4'd0))
    // every digit out of the dabble register is decimal
    `SITDD_ASSERT(a_digit_decimal, o_valid |-> (o_digit <= 4'd9))

endmodule
